>>> rtl/pse_pkg.sv
// Shared types and constants of the peak-seeded blob extent search.
`default_nettype none

package pse_pkg;

	localparam int PLANE_WIDTH_DEF  = 40;
	localparam int PLANE_HEIGHT_DEF = 60;

	localparam int PIX_W = 8;
	localparam int COL_OUT_W = 6;
	localparam int ROW_OUT_W = 6;

	localparam logic [PIX_W-1:0] THRESHOLD_RST = 8'd10;

	// Verdict of the shared compare unit on one sample against the peak
	typedef struct packed {
		logic gt;
		logic member;
		logic seed_ok;
	} cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/peak_seeded_blob_extent.sv
// Top level of the peak-seeded blob extent search.
//
// Input channel (in_valid / in_stall): one word per chroma sample, row-major,
// frame_end set on the last word of the frame. Words load into the frame store
// at one per cycle while idle; words past the end of the store are dropped.
// On the frame_end word the block raises in_stall and searches the store:
// a peak scan over every stored sample (one read of the single store read
// port per cycle), then for each searched row a seed read and evaluation,
// a read and evaluation per neighbor sample visited, and a step to close
// the row. All of it runs through one compare unit and one read port.
// Output channel (out_valid / out_stall): one word per frame with left,
// right, middle, bottom row and peak level. The result sits in its own
// register, so loading of the next frame goes on while the receiver stalls;
// a finished search only waits there if the previous result is still held.
// cfg_wr_en / cfg_wr_data write the threshold (reset 10); write it only
// while the block is idle.
// Reset clears the load position, the sequencer and the result valid; the
// frame store keeps no reset and must be filled before a search.
`default_nettype none

module peak_seeded_blob_extent #(
	parameter int PLANE_WIDTH  = pse_pkg::PLANE_WIDTH_DEF,
	parameter int PLANE_HEIGHT = pse_pkg::PLANE_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pse_pkg::PIX_W-1:0]      cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pse_pkg::PIX_W-1:0]      pixel,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_left,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_right,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_middle,
	output logic [pse_pkg::ROW_OUT_W-1:0]  blob_bottom,
	output logic [pse_pkg::PIX_W-1:0]      peak_level
);
	import pse_pkg::*;

	localparam int DEPTH = PLANE_WIDTH * PLANE_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [PIX_W-1:0] thr_q;
	logic             mem_wr_en;
	logic [AW-1:0]    mem_wr_addr;
	logic [PIX_W-1:0] mem_wr_data;
	logic             mem_rd_en;
	logic [AW-1:0]    mem_rd_addr;
	logic [PIX_W-1:0] mem_rd_data;

	// Threshold register: written directly, no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	pse_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	pse_seq #(
		.PLANE_WIDTH  (PLANE_WIDTH),
		.PLANE_HEIGHT (PLANE_HEIGHT),
		.DEPTH        (DEPTH),
		.AW           (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.thr         (thr_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel       (pixel),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.blob_left   (blob_left),
		.blob_right  (blob_right),
		.blob_middle (blob_middle),
		.blob_bottom (blob_bottom),
		.peak_level  (peak_level),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

`ifndef SYNTHESIS
	// A frame_end word starts the search at once
	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && frame_end |=> in_stall)
		else $error("search did not start after frame_end");

	// A result only appears at the end of a search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without a search");

	// The threshold takes the written value
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> thr_q == $past(cfg_wr_data))
		else $error("threshold write lost");
`endif

endmodule

`default_nettype wire

>>> rtl/pse_store.sv
// Frame store: one write port, one read port with registered read data.
`default_nettype none

module pse_store #(
	parameter int DEPTH = pse_pkg::PLANE_WIDTH_DEF * pse_pkg::PLANE_HEIGHT_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [AW-1:0]              wr_addr,
	input  logic [pse_pkg::PIX_W-1:0]  wr_data,
	input  logic                       rd_en,
	input  logic [AW-1:0]              rd_addr,
	output logic [pse_pkg::PIX_W-1:0]  rd_data
);
	import pse_pkg::*;

	logic [PIX_W-1:0] mem_q [DEPTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/pse_cmp.sv
// Shared compare unit: sample against peak and threshold.
`default_nettype none

module pse_cmp (
	input  logic [pse_pkg::PIX_W-1:0] sample,
	input  logic [pse_pkg::PIX_W-1:0] peak,
	input  logic [pse_pkg::PIX_W-1:0] thr,
	output pse_pkg::cmp_res_t         res
);
	import pse_pkg::*;

	logic [PIX_W:0] diff;

	// A sample above the peak wraps far away and never belongs
	assign diff        = {1'b0, peak} - {1'b0, sample};
	assign res.gt      = diff[PIX_W];
	assign res.member  = !diff[PIX_W] && (diff[PIX_W-1:0] <= thr);
	assign res.seed_ok = !diff[PIX_W] && (diff[PIX_W-1:0] < thr);

endmodule

`default_nettype wire

>>> rtl/pse_seq.sv
// Sequencer: frame load, peak scan, upward and downward row searches, result register.
`default_nettype none

module pse_seq #(
	parameter int PLANE_WIDTH  = pse_pkg::PLANE_WIDTH_DEF,
	parameter int PLANE_HEIGHT = pse_pkg::PLANE_HEIGHT_DEF,
	parameter int DEPTH        = PLANE_WIDTH * PLANE_HEIGHT,
	parameter int AW           = $clog2(DEPTH)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [pse_pkg::PIX_W-1:0]      thr,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pse_pkg::PIX_W-1:0]      pixel,
	input  logic                           frame_end,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_left,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_right,
	output logic [pse_pkg::COL_OUT_W-1:0]  blob_middle,
	output logic [pse_pkg::ROW_OUT_W-1:0]  blob_bottom,
	output logic [pse_pkg::PIX_W-1:0]      peak_level,
	output logic                           mem_wr_en,
	output logic [AW-1:0]                  mem_wr_addr,
	output logic [pse_pkg::PIX_W-1:0]      mem_wr_data,
	output logic                           mem_rd_en,
	output logic [AW-1:0]                  mem_rd_addr,
	input  logic [pse_pkg::PIX_W-1:0]      mem_rd_data
);
	import pse_pkg::*;

	localparam int COL_W = $clog2(PLANE_WIDTH);
	localparam int ROW_W = $clog2(PLANE_HEIGHT + 1);
	localparam int LP_W  = $clog2(DEPTH + 1);

	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(PLANE_WIDTH - 1);
	localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(PLANE_HEIGHT - 1);
	localparam logic [ROW_W-1:0] ROW_END   = ROW_W'(PLANE_HEIGHT);
	localparam logic [AW-1:0]    ADDR_LAST = AW'(DEPTH - 1);
	localparam logic [AW-1:0]    ROW_STEP  = AW'(PLANE_WIDTH);
	localparam logic [LP_W-1:0]  LOAD_FULL = LP_W'(DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PK_RUN,
		ST_PK_END,
		ST_UP_INIT,
		ST_SEED_RD,
		ST_SEED_EV,
		ST_LEFT_RD,
		ST_LEFT_EV,
		ST_RIGHT_RD,
		ST_RIGHT_EV,
		ST_ROW_DONE,
		ST_DN_INIT,
		ST_FIN
	} state_t;

	function automatic logic [COL_W-1:0] mid_of(input logic [COL_W-1:0] lo,
	                                             input logic [COL_W-1:0] hi);
		logic [COL_W-1:0] span;
		span = hi - lo;
		return lo + (span >> 1);
	endfunction

	state_t           state_q;
	logic [LP_W-1:0]  load_q;
	logic [AW-1:0]    pk_addr_q;
	logic [AW-1:0]    pk_base_q;
	logic [COL_W-1:0] pk_col_q;
	logic [ROW_W-1:0] pk_row_q;
	logic             pk_v_s1;
	logic [AW-1:0]    pk_base_s1;
	logic [COL_W-1:0] pk_col_s1;
	logic [ROW_W-1:0] pk_row_s1;
	logic [PIX_W-1:0] peak_q;
	logic [COL_W-1:0] pcol_q;
	logic [ROW_W-1:0] prow_q;
	logic [AW-1:0]    pbase_q;
	logic [COL_W-1:0] ext_l_q;
	logic [COL_W-1:0] ext_r_q;
	logic [COL_W-1:0] seed_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] lo_q;
	logic [COL_W-1:0] hi_q;
	logic [ROW_W-1:0] row_q;
	logic [AW-1:0]    base_q;
	logic             dir_up_q;
	logic             out_valid_q;
	logic [COL_OUT_W-1:0] out_left_q;
	logic [COL_OUT_W-1:0] out_right_q;
	logic [COL_OUT_W-1:0] out_mid_q;
	logic [ROW_OUT_W-1:0] out_bottom_q;
	logic [PIX_W-1:0]     out_peak_q;

	logic             in_acc;
	logic             slot_free;
	logic [COL_W-1:0] rd_col;
	logic [COL_W-1:0] new_l;
	logic [COL_W-1:0] new_r;
	cmp_res_t         cmp;

	pse_cmp u_cmp (
		.sample (mem_rd_data),
		.peak   (peak_q),
		.thr    (thr),
		.res    (cmp)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign in_acc      = in_valid && (state_q == ST_IDLE);
	assign slot_free   = !out_valid_q || !out_stall;

	assign mem_wr_en   = in_acc && (load_q < LOAD_FULL);
	assign mem_wr_addr = load_q[AW-1:0];
	assign mem_wr_data = pixel;

	assign rd_col      = (state_q == ST_SEED_RD) ? seed_q : col_q;
	assign mem_rd_en   = (state_q == ST_PK_RUN) || (state_q == ST_SEED_RD) ||
	                     (state_q == ST_LEFT_RD) || (state_q == ST_RIGHT_RD);
	assign mem_rd_addr = (state_q == ST_PK_RUN) ? pk_addr_q : base_q + AW'(rd_col);

	assign new_l = (lo_q < ext_l_q) ? lo_q : ext_l_q;
	assign new_r = (hi_q > ext_r_q) ? hi_q : ext_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			load_q       <= '0;
			pk_addr_q    <= '0;
			pk_base_q    <= '0;
			pk_col_q     <= '0;
			pk_row_q     <= '0;
			pk_v_s1      <= 1'b0;
			pk_base_s1   <= '0;
			pk_col_s1    <= '0;
			pk_row_s1    <= '0;
			peak_q       <= '0;
			pcol_q       <= '0;
			prow_q       <= '0;
			pbase_q      <= '0;
			ext_l_q      <= '0;
			ext_r_q      <= '0;
			seed_q       <= '0;
			col_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			row_q        <= '0;
			base_q       <= '0;
			dir_up_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_left_q   <= '0;
			out_right_q  <= '0;
			out_mid_q    <= '0;
			out_bottom_q <= '0;
			out_peak_q   <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Peak scan pipeline: data of the address issued last cycle is here now
			pk_v_s1    <= (state_q == ST_PK_RUN);
			pk_base_s1 <= pk_base_q;
			pk_col_s1  <= pk_col_q;
			pk_row_s1  <= pk_row_q;
			if (pk_v_s1 && cmp.gt) begin
				peak_q  <= mem_rd_data;
				pcol_q  <= pk_col_s1;
				prow_q  <= pk_row_s1;
				pbase_q <= pk_base_s1;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (load_q < LOAD_FULL) begin
							load_q <= load_q + LP_W'(1);
						end
						if (frame_end) begin
							load_q    <= '0;
							pk_addr_q <= '0;
							pk_base_q <= '0;
							pk_col_q  <= '0;
							pk_row_q  <= '0;
							peak_q    <= '0;
							pcol_q    <= '0;
							prow_q    <= '0;
							pbase_q   <= '0;
							state_q   <= ST_PK_RUN;
						end
					end
				end
				ST_PK_RUN: begin
					if (pk_addr_q == ADDR_LAST) begin
						state_q <= ST_PK_END;
					end else begin
						pk_addr_q <= pk_addr_q + AW'(1);
						if (pk_col_q == COL_LAST) begin
							pk_col_q  <= '0;
							pk_row_q  <= pk_row_q + ROW_W'(1);
							pk_base_q <= pk_base_q + ROW_STEP;
						end else begin
							pk_col_q <= pk_col_q + COL_W'(1);
						end
					end
				end
				ST_PK_END: begin
					// Last sample is compared this cycle
					state_q <= ST_UP_INIT;
				end
				ST_UP_INIT: begin
					ext_l_q  <= pcol_q;
					ext_r_q  <= pcol_q;
					seed_q   <= pcol_q;
					row_q    <= prow_q;
					base_q   <= pbase_q;
					dir_up_q <= 1'b1;
					state_q  <= ST_SEED_RD;
				end
				ST_SEED_RD: begin
					state_q <= ST_SEED_EV;
				end
				ST_SEED_EV: begin
					if (!cmp.seed_ok) begin
						state_q <= dir_up_q ? ST_DN_INIT : ST_FIN;
					end else begin
						lo_q <= seed_q;
						hi_q <= seed_q;
						if (seed_q != '0) begin
							col_q   <= seed_q - COL_W'(1);
							state_q <= ST_LEFT_RD;
						end else if (seed_q != COL_LAST) begin
							col_q   <= seed_q + COL_W'(1);
							state_q <= ST_RIGHT_RD;
						end else begin
							state_q <= ST_ROW_DONE;
						end
					end
				end
				ST_LEFT_RD: begin
					state_q <= ST_LEFT_EV;
				end
				ST_LEFT_EV: begin
					if (cmp.member) begin
						lo_q <= col_q;
					end
					if (cmp.member && (col_q != '0)) begin
						col_q   <= col_q - COL_W'(1);
						state_q <= ST_LEFT_RD;
					end else if (seed_q != COL_LAST) begin
						col_q   <= seed_q + COL_W'(1);
						state_q <= ST_RIGHT_RD;
					end else begin
						state_q <= ST_ROW_DONE;
					end
				end
				ST_RIGHT_RD: begin
					state_q <= ST_RIGHT_EV;
				end
				ST_RIGHT_EV: begin
					if (cmp.member) begin
						hi_q <= col_q;
					end
					if (cmp.member && (col_q != COL_LAST)) begin
						col_q   <= col_q + COL_W'(1);
						state_q <= ST_RIGHT_RD;
					end else begin
						state_q <= ST_ROW_DONE;
					end
				end
				ST_ROW_DONE: begin
					ext_l_q <= new_l;
					ext_r_q <= new_r;
					if (dir_up_q) begin
						seed_q <= mid_of(lo_q, hi_q);
						if (row_q == '0) begin
							state_q <= ST_DN_INIT;
						end else begin
							row_q   <= row_q - ROW_W'(1);
							base_q  <= base_q - ROW_STEP;
							state_q <= ST_SEED_RD;
						end
					end else if (row_q == ROW_LAST) begin
						row_q   <= ROW_END;
						state_q <= ST_FIN;
					end else begin
						row_q   <= row_q + ROW_W'(1);
						base_q  <= base_q + ROW_STEP;
						state_q <= ST_SEED_RD;
					end
				end
				ST_DN_INIT: begin
					seed_q   <= mid_of(ext_l_q, ext_r_q);
					row_q    <= prow_q;
					base_q   <= pbase_q;
					dir_up_q <= 1'b0;
					state_q  <= ST_SEED_RD;
				end
				ST_FIN: begin
					// Hold until the result register is free
					if (slot_free) begin
						out_valid_q  <= 1'b1;
						out_left_q   <= COL_OUT_W'(ext_l_q);
						out_right_q  <= COL_OUT_W'(ext_r_q);
						out_mid_q    <= COL_OUT_W'(mid_of(ext_l_q, ext_r_q));
						out_bottom_q <= ROW_OUT_W'(row_q);
						out_peak_q   <= peak_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign blob_left   = out_left_q;
	assign blob_right  = out_right_q;
	assign blob_middle = out_mid_q;
	assign blob_bottom = out_bottom_q;
	assign peak_level  = out_peak_q;

endmodule

`default_nettype wire

>>> test/peak_seeded_blob_extent_tb.sv
// Self-checking testbench for the peak-seeded blob extent search block.
`timescale 1ns / 100ps

module peak_seeded_blob_extent_tb;
	import pse_pkg::*;

	localparam int PW            = PLANE_WIDTH_DEF;
	localparam int PH            = PLANE_HEIGHT_DEF;
	localparam int STORE_DEPTH   = PW * PH;
	// Quiet cycles after the last result before touching the threshold or ending.
	localparam int SETTLE_CYCLES = 40;
	// Long output hold-off: spans several short-frame searches, so the result
	// register fills, a finished search parks behind it and the input stalls.
	localparam int SQUEEZE_CYCLES = 12000;

	// One input word: a chroma sample and its end-of-frame mark.
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} sample_t;

	// One blob result as the block reports it.
	typedef struct packed {
		logic [COL_OUT_W-1:0] left;
		logic [COL_OUT_W-1:0] right;
		logic [COL_OUT_W-1:0] middle;
		logic [ROW_OUT_W-1:0] bottom;
		logic [PIX_W-1:0]     peak;
	} extent_t;

	logic                 clk;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [PIX_W-1:0]     cfg_wr_data = '0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic [PIX_W-1:0]     pixel       = '0;
	logic                 frame_end   = 1'b0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [COL_OUT_W-1:0] blob_left;
	logic [COL_OUT_W-1:0] blob_right;
	logic [COL_OUT_W-1:0] blob_middle;
	logic [ROW_OUT_W-1:0] blob_bottom;
	logic [PIX_W-1:0]     peak_level;

	peak_seeded_blob_extent #(
		.PLANE_WIDTH (PW),
		.PLANE_HEIGHT(PH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.frame_end  (frame_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.blob_left  (blob_left),
		.blob_right (blob_right),
		.blob_middle(blob_middle),
		.blob_bottom(blob_bottom),
		.peak_level (peak_level)
	);

	// Words waiting to be offered, and results owed by the block, oldest first.
	sample_t sample_q[$];
	extent_t pending_extents[$];

	// Shadow of the block: frame store, load position, threshold and search state.
	bit [PIX_W-1:0] frame_copy [STORE_DEPTH];
	bit [PIX_W-1:0] cur_threshold = THRESHOLD_RST;
	int             fill_pos;
	int             frame_len;
	int             peak_val, peak_col, peak_row;
	int             ext_left, ext_right;

	// Scratch frame that stimulus is painted into before it is queued.
	bit [PIX_W-1:0] canvas [STORE_DEPTH];

	int  errors;
	int  words_queued, words_taken;
	int  frames_done, full_frames, results_seen;
	int  gap_left, stall_left, hold_left;
	bit  word_taken;
	bit  calm;
	bit  squeeze_armed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample-vs-peak test. The seed test is strict (a row is entered only while its
	// seed lies less than threshold below the peak); run membership is inclusive.
	function automatic bit near_peak(int row, int col, bit seed_test);
		int gap;
		gap = peak_val - int'(frame_copy[row * PW + col]);
		return seed_test ? (gap < int'(cur_threshold)) : (gap <= int'(cur_threshold));
	endfunction

	// Grow the member run around the seed on one row, widen the overall extent,
	// and hand back the middle of this row's run.
	function automatic int sweep_row(int row, int seed);
		int lo, hi, col;
		lo  = seed;
		hi  = seed;
		col = seed;
		while (near_peak(row, col, 1'b0)) begin
			lo = col;
			if (col == 0)
				break;
			col--;
		end
		for (col = seed + 1; col < PW; col++) begin
			if (!near_peak(row, col, 1'b0))
				break;
			hi = col;
		end
		if (lo < ext_left)
			ext_left = lo;
		if (hi > ext_right)
			ext_right = hi;
		return lo + (hi - lo) / 2;
	endfunction

	// Full search over the shadow store: peak, climb up, then descend.
	function automatic extent_t locate_blob();
		int      a, row, seed;
		extent_t found;
		peak_val = 0;
		peak_col = 0;
		peak_row = 0;
		// first strictly greatest sample in scan order wins
		for (a = 0; a < STORE_DEPTH; a++) begin
			if (frame_copy[a] > peak_val) begin
				peak_val = frame_copy[a];
				peak_col = a % PW;
				peak_row = a / PW;
			end
		end
		ext_left  = peak_col;
		ext_right = peak_col;
		// climb: each accepted row passes the middle of its run to the row above
		seed = peak_col;
		row  = peak_row;
		while (row >= 0 && near_peak(row, seed, 1'b1)) begin
			seed = sweep_row(row, seed);
			row--;
		end
		// descend from the peak row with the seed pinned to the extent middle
		seed = ext_left + (ext_right - ext_left) / 2;
		row  = peak_row;
		while (row < PH && near_peak(row, seed, 1'b1)) begin
			void'(sweep_row(row, seed));
			row++;
		end
		found.left   = ext_left;
		found.right  = ext_right;
		found.middle = ext_left + (ext_right - ext_left) / 2;
		found.bottom = row;
		found.peak   = peak_val;
		return found;
	endfunction

	// Load one accepted word into the shadow; on frame end, owe one result.
	function automatic void absorb_sample(logic [PIX_W-1:0] pix, logic last);
		// drop words past the end of the store
		if (fill_pos < STORE_DEPTH) begin
			frame_copy[fill_pos] = pix;
			fill_pos++;
		end
		frame_len++;
		if (last) begin
			pending_extents.push_back(locate_blob());
			frames_done++;
			if (frame_len >= STORE_DEPTH)
				full_frames++;
			fill_pos  = 0;
			frame_len = 0;
		end
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Observe both channels at the rising edge: check results, then absorb words.
	always @(posedge clk) begin : observe
		extent_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_extents.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected result, expected none, got left %0d right %0d",
						$time, blob_left, blob_right);
				end else begin
					want = pending_extents.pop_front();
					check_field("blob_left", want.left, blob_left);
					check_field("blob_right", want.right, blob_right);
					check_field("blob_middle", want.middle, blob_middle);
					check_field("blob_bottom", want.bottom, blob_bottom);
					check_field("peak_level", want.peak, peak_level);
				end
			end
			if (in_valid && !in_stall) begin
				absorb_sample(pixel, frame_end);
				words_taken++;
				word_taken = 1'b1;
			end
		end
	end

	// Input driver: hold a stalled word, otherwise advance, now and then idling
	// for a burst of random length. Valid never looks at stall.
	always @(negedge clk) begin : feed
		sample_t nxt_word;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			pixel     <= '0;
			frame_end <= 1'b0;
		end else if (!in_valid || word_taken) begin
			word_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(0, 8);
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				nxt_word = sample_q.pop_front();
				pixel     <= nxt_word.pix;
				frame_end <= nxt_word.last;
				in_valid  <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stall bursts, plus one long counted hold-off on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (squeeze_armed) begin
			squeeze_armed = 1'b0;
			hold_left = SQUEEZE_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic write_threshold(input bit [PIX_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		cur_threshold = value;
	endtask

	// Wait until every queued word is taken and every owed result has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (words_taken != words_queued || pending_extents.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic paint_flat(input int level);
		int i;
		for (i = 0; i < STORE_DEPTH; i++)
			canvas[i] = level;
	endtask

	task automatic paint_noise(input int top);
		int i;
		for (i = 0; i < STORE_DEPTH; i++)
			canvas[i] = $urandom_range(0, top);
	endtask

	// Noise background with a drifting blob whose samples sit just around the
	// threshold below its peak, so both membership edges get hit.
	task automatic paint_blob(input int bg_max, input int top_rows);
		int pk, r0, c0, reach, row, col, half, mid, spread, dip;
		pk     = $urandom_range(bg_max, 255);
		spread = int'(cur_threshold) + 2;
		paint_noise(bg_max);
		r0    = $urandom_range(0, top_rows - 1);
		c0    = $urandom_range(0, PW - 1);
		reach = $urandom_range(0, 20);
		mid   = c0;
		for (row = r0 - reach; row <= r0 + reach; row++) begin
			half = $urandom_range(0, 12);
			mid  = mid + int'($urandom_range(0, 4)) - 2;
			if (mid < 0)
				mid = 0;
			if (mid > PW - 1)
				mid = PW - 1;
			if (row >= 0 && row < PH) begin
				for (col = mid - half; col <= mid + half; col++) begin
					if (col >= 0 && col < PW) begin
						dip = (pk > spread) ? $urandom_range(0, spread) : $urandom_range(0, pk);
						canvas[row * PW + col] = pk - dip;
					end
				end
			end
		end
		canvas[r0 * PW + c0] = pk;
	endtask

	// Queue the first n words of the canvas; words past the store get noise.
	task automatic queue_frame(input int n);
		int      i;
		sample_t s;
		for (i = 0; i < n; i++) begin
			s.pix  = (i < STORE_DEPTH) ? canvas[i] : $urandom_range(0, 255);
			s.last = (i == n - 1);
			sample_q.push_back(s);
		end
		words_queued += n;
	endtask

	// One random phase at a given threshold: mostly short blob frames near the
	// top rows, short noise and, if full_ok, full blob and overlong noise frames.
	task automatic run_phase(input bit [PIX_W-1:0] thr, input int n_frames,
			input bit full_ok, input bit squeeze);
		int f, kind;
		write_threshold(thr);
		@(posedge clk);
		if (squeeze)
			squeeze_armed = 1'b1;
		for (f = 0; f < n_frames; f++) begin
			kind = $urandom_range(0, 9);
			if (full_ok && kind < 2) begin
				paint_blob($urandom_range(0, 255), PH);
				queue_frame(STORE_DEPTH);
			end else if (full_ok && kind == 2) begin
				paint_noise(255);
				queue_frame(STORE_DEPTH + $urandom_range(1, 40));
			end else if (kind == 3) begin
				paint_noise($urandom_range(0, 255));
				queue_frame($urandom_range(1, 300));
			end else begin
				paint_blob($urandom_range(0, 255), 8);
				queue_frame($urandom_range(1, 300));
			end
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed frames at the reset threshold. The first frame fills the
		// whole store so that no search ever reads an unwritten entry.
		@(posedge clk);
		paint_flat(0);
		queue_frame(STORE_DEPTH);           // flat zero: blob covers the plane
		canvas[STORE_DEPTH - 1] = 255;
		queue_frame(STORE_DEPTH);           // lone peak in the very last corner
		canvas[0] = 128;
		queue_frame(1);                     // frame end on the first word
		paint_flat(255);
		queue_frame(STORE_DEPTH);           // flat full scale
		paint_noise(255);
		queue_frame(STORE_DEPTH + 7);       // overlong frame: tail is dropped
		paint_blob(60, 3);
		queue_frame(100);                   // short frame over older content
		drain();

		// Zero threshold: no row passes the seed test.
		write_threshold(0);
		@(posedge clk);
		paint_blob(100, PH);
		queue_frame(STORE_DEPTH);
		paint_blob(0, 1);
		queue_frame(40);
		drain();

		// Full-scale threshold: only a zero under a 255 peak fails the seed test.
		write_threshold(255);
		@(posedge clk);
		paint_flat(0);
		canvas[$urandom_range(0, STORE_DEPTH - 1)] = 255;
		queue_frame(STORE_DEPTH);
		paint_blob(255, PH);
		queue_frame(STORE_DEPTH);
		drain();

		// Random phases; the second one also squeezes the output side.
		run_phase($urandom_range(1, 40), 12, 1'b1, 1'b0);
		run_phase(1, 10, 1'b0, 1'b1);
		run_phase($urandom_range(0, 255), 12, 1'b1, 1'b0);
		run_phase(254, 10, 1'b1, 1'b0);
		// last stretch without any idling on either side
		calm = 1'b1;
		run_phase($urandom_range(2, 30), 10, 1'b1, 1'b0);

		repeat (200) @(negedge clk);
		if (pending_extents.size() != 0) begin
			errors++;
			$display("%0t ns: %0d blob results expected, 0 received",
				$time, pending_extents.size());
		end

		$display("Searched %0d frames (%0d full or overlong) from %0d words, %0d results seen;",
			frames_done, full_frames, words_taken, results_seen);
		$display("thresholds 0, 1, 10, 254, 255 and random, with a long output hold-off.");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#60000000;
		$display("%0t ns: watchdog expired, %0d results still owed", $time,
			pending_extents.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> peak_seeded_blob_extent.f
rtl/pse_pkg.sv
rtl/pse_store.sv
rtl/pse_cmp.sv
rtl/pse_seq.sv
rtl/peak_seeded_blob_extent.sv
test/peak_seeded_blob_extent_tb.sv
